// ===== src/mtfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfd_pkg
// Shared constants and types for the multi-converter thermocouple frame
// decoder: frame layout, status codes, junction limits and the per-lane report.
// ----------------------------------------------------------------------------
package mtfd_pkg;

  localparam int PORT_COUNT = 16;
  localparam int PORT_W     = 4;
  localparam int FRAME_W    = 32;
  localparam int CNT_W      = 5;
  localparam int THERMO_W   = 14;
  localparam int JCT_W      = 12;
  localparam int STATUS_W   = 3;
  localparam int OKCNT_W    = 5;
  localparam int SUM_W      = 16;

  // frame bit positions
  localparam int FAULT_BIT  = 16;
  localparam int THERMO_LSB = 18;
  localparam int JCT_LSB    = 4;

  localparam logic [STATUS_W-1:0] ST_VALID = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OPEN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_VCC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEVER = 3'd4;

  // fault code field (low three bits of the frame)
  localparam logic [2:0] FC_OPEN = 3'b001;
  localparam logic [2:0] FC_GND  = 3'b010;
  localparam logic [2:0] FC_VCC  = 3'b100;

  // -10 and +100 degrees in 1/16 degree units
  localparam logic signed [JCT_W-1:0] JCT_LOW  = -12'sd160;
  localparam logic signed [JCT_W-1:0] JCT_HIGH = 12'sd1600;

  localparam logic [CNT_W-1:0] LAST_SLICE = CNT_W'(FRAME_W - 1);

  typedef struct packed {
    logic signed [THERMO_W-1:0] value;   // already zero unless status is valid
    logic [STATUS_W-1:0]        status;
    logic signed [JCT_W-1:0]    jcode;
  } lane_rpt_t;

endpackage

// ===== src/mtfd_lane.sv =====
// ----------------------------------------------------------------------------
// mtfd_lane
// One converter lane: 32-bit frame shift register, frame decode, and the
// stored thermocouple reading with its replacement rule.
// ----------------------------------------------------------------------------
module mtfd_lane
  import mtfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift_en,
  input  logic      first,
  input  logic      so_bit,
  input  logic      frame_end,
  input  logic      overwrite,
  output lane_rpt_t rpt
);

  logic [FRAME_W-1:0]         frame_r, frame_nxt;
  logic signed [THERMO_W-1:0] value_r, new_value;
  logic [STATUS_W-1:0]        status_r, new_status;
  logic signed [JCT_W-1:0]    jcode_r;
  logic                       replace;

  always_comb begin
    frame_nxt = {(first ? FRAME_W'(0) : frame_r) << 1};
    frame_nxt[0] = so_bit;
  end

  always_comb begin
    new_status = ST_VALID;
    new_value  = '0;
    if (frame_nxt[FAULT_BIT]) begin
      unique case (frame_nxt[2:0])
        FC_OPEN: new_status = ST_OPEN;
        FC_GND:  new_status = ST_GND;
        FC_VCC:  new_status = ST_VCC;
        default: new_status = ST_VALID;   // unknown fault code reads as valid zero
      endcase
    end else begin
      new_value = frame_nxt[THERMO_LSB +: THERMO_W];
    end
  end

  assign replace = overwrite || (new_status == ST_VALID) || (status_r == ST_NEVER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      value_r  <= '0;
      status_r <= ST_NEVER;
    end else if (shift_en) begin
      frame_r <= frame_nxt;
      if (frame_end && replace) begin
        value_r  <= new_value;
        status_r <= new_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en && frame_end) begin
      jcode_r <= frame_nxt[JCT_LSB +: JCT_W];
    end
  end

  assign rpt.value  = (status_r == ST_VALID) ? value_r : '0;
  assign rpt.status = status_r;
  assign rpt.jcode  = jcode_r;

endmodule

// ===== src/mtfd_merge.sv =====
// ----------------------------------------------------------------------------
// mtfd_merge
// Walks the lanes one per cycle after a frame end unless the output is stalled,
// drives the result register and accumulates valid count, junction sum and range flag.
// ----------------------------------------------------------------------------
module mtfd_merge
  import mtfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  lane_rpt_t                  rpt [PORT_COUNT],
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [PORT_W-1:0]          out_port,
  output logic signed [THERMO_W-1:0] out_thermo_quarter_deg,
  output logic [STATUS_W-1:0]        out_thermo_status,
  output logic signed [JCT_W-1:0]    out_junction_sixteenth_deg,
  output logic                       out_last,
  output logic [OKCNT_W-1:0]         out_ok_count,
  output logic signed [SUM_W-1:0]    out_junction_sum,
  output logic                       out_junction_out_of_range
);

  logic                       busy_r, busy_nxt;
  logic [PORT_W-1:0]          idx_r, idx_nxt;
  logic                       ovld_r, ovld_nxt;
  logic [OKCNT_W-1:0]         ok_r, ok_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       oor_r, oor_nxt;
  logic                       load, is_last;
  lane_rpt_t                  sel;

  logic [PORT_W-1:0]          port_r;
  logic signed [THERMO_W-1:0] thermo_r;
  logic [STATUS_W-1:0]        status_r;
  logic signed [JCT_W-1:0]    jct_r;
  logic                       last_r;
  logic [OKCNT_W-1:0]         okc_out_r;
  logic signed [SUM_W-1:0]    sum_out_r;
  logic                       oor_out_r;

  assign sel     = rpt[idx_r];
  assign load    = busy_r && (!ovld_r || !out_stall);
  assign is_last = (idx_r == PORT_W'(PORT_COUNT - 1));

  assign ok_nxt  = ok_r + OKCNT_W'(sel.status == ST_VALID);
  assign sum_nxt = sum_r + SUM_W'(sel.jcode);
  assign oor_nxt = oor_r || (sel.jcode < JCT_LOW) || (sel.jcode > JCT_HIGH);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (load) begin
      busy_nxt = !is_last;
      idx_nxt  = idx_r + PORT_W'(1);
    end
    if (load) begin
      ovld_nxt = 1'b1;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
      ok_r   <= '0;
      sum_r  <= '0;
      oor_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
      if (start) begin
        ok_r  <= '0;
        sum_r <= '0;
        oor_r <= 1'b0;
      end else if (load) begin
        ok_r  <= ok_nxt;
        sum_r <= sum_nxt;
        oor_r <= oor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      port_r    <= idx_r;
      thermo_r  <= sel.value;
      status_r  <= sel.status;
      jct_r     <= sel.jcode;
      last_r    <= is_last;
      okc_out_r <= is_last ? ok_nxt : '0;
      sum_out_r <= is_last ? sum_nxt : '0;
      oor_out_r <= is_last && oor_nxt;
    end
  end

  assign busy                       = busy_r;
  assign out_valid                  = ovld_r;
  assign out_port                   = port_r;
  assign out_thermo_quarter_deg     = thermo_r;
  assign out_thermo_status          = status_r;
  assign out_junction_sixteenth_deg = jct_r;
  assign out_last                   = last_r;
  assign out_ok_count               = okc_out_r;
  assign out_junction_sum           = sum_out_r;
  assign out_junction_out_of_range  = oor_out_r;

  // a new frame never ends while the previous one is still being emitted
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("frame end during emission");

  // the walk finishes on the final lane
  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    load && is_last |=> !busy_r && ovld_r && last_r)
    else $error("walk did not finish on last lane");

  // the lane pointer only moves on a load or a start
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load && !start |=> $stable(idx_r))
    else $error("lane index moved without a load");

  // the valid count never exceeds the number of lanes
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && last_r |-> okc_out_r <= OKCNT_W'(PORT_COUNT))
    else $error("valid count out of range");

endmodule

// ===== src/multi_thermocouple_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// multi_thermocouple_frame_decoder
// Shifts one sampled bit per converter per slice into 32-bit frames, decodes
// all frames at frame end in parallel lanes and emits one result per port.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | so_bits, first_bit, overwrite
//  out_    | output    | out_valid/out_stall | port .. junction_out_of_range
//
//  One slice is taken per cycle unless in_stall is raised. On the 32nd slice all 16 lanes
//  decode at once; the merge stage then loads one port result per cycle while out_stall
//  is low. in_stall is raised only for a slice that would end a frame while the
//  previous frame's results are still being loaded into the output register.
//  Synchronous active-low reset: stored status reads "never read", counter zero.
// ----------------------------------------------------------------------------
module multi_thermocouple_frame_decoder
  import mtfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [PORT_COUNT-1:0]      in_so_bits,
  input  logic                       in_first_bit,
  input  logic                       in_overwrite,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [PORT_W-1:0]          out_port,
  output logic signed [THERMO_W-1:0] out_thermo_quarter_deg,
  output logic [STATUS_W-1:0]        out_thermo_status,
  output logic signed [JCT_W-1:0]    out_junction_sixteenth_deg,
  output logic                       out_last,
  output logic [OKCNT_W-1:0]         out_ok_count,
  output logic signed [SUM_W-1:0]    out_junction_sum,
  output logic                       out_junction_out_of_range
);

  logic [CNT_W-1:0] cnt_r, cnt_base;
  logic             frame_hit, accept, busy;
  lane_rpt_t        rpt [PORT_COUNT];

  assign cnt_base  = in_first_bit ? '0 : cnt_r;
  assign frame_hit = (cnt_base == LAST_SLICE);
  assign in_stall  = busy && frame_hit;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= frame_hit ? '0 : cnt_base + CNT_W'(1);
    end
  end

  for (genvar g = 0; g < PORT_COUNT; g++) begin : g_lane
    mtfd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (accept),
      .first     (in_first_bit),
      .so_bit    (in_so_bits[g]),
      .frame_end (frame_hit),
      .overwrite (in_overwrite),
      .rpt       (rpt[g])
    );
  end

  mtfd_merge u_merge (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .start                      (accept && frame_hit),
    .rpt                        (rpt),
    .busy                       (busy),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_port                   (out_port),
    .out_thermo_quarter_deg     (out_thermo_quarter_deg),
    .out_thermo_status          (out_thermo_status),
    .out_junction_sixteenth_deg (out_junction_sixteenth_deg),
    .out_last                   (out_last),
    .out_ok_count               (out_ok_count),
    .out_junction_sum           (out_junction_sum),
    .out_junction_out_of_range  (out_junction_out_of_range)
  );

endmodule

// ===== dv/multi_thermocouple_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_thermocouple_frame_decoder_tb
// Feeds bit slices that build 32-bit converter frames: clean frames with
// random readings, faults and junction limits, plus stray slices and restarted
// frames. A predictor in the bench decodes each accepted slice and queues the
// 16 port reports of every finished frame. The monitor checks each report
// transfer against the oldest queued report. Sender and receiver stall at
// random in the first two of three phases, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module multi_thermocouple_frame_decoder_tb;
  import mtfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SLICES_PER_PHASE = 85;

  typedef struct packed {
    logic [PORT_COUNT-1:0] so_bits;
    logic                  first_bit;
    logic                  overwrite;
  } slice_t;

  typedef struct packed {
    logic [PORT_W-1:0]          port;
    logic signed [THERMO_W-1:0] thermo;
    logic [STATUS_W-1:0]        status;
    logic signed [JCT_W-1:0]    jct;
    logic                       last;
    logic [OKCNT_W-1:0]         ok_count;
    logic signed [SUM_W-1:0]    jsum;
    logic                       oor;
  } port_report_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [PORT_COUNT-1:0]      in_so_bits = '0;
  logic                       in_first_bit = 1'b0;
  logic                       in_overwrite = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [PORT_W-1:0]          out_port;
  logic signed [THERMO_W-1:0] out_thermo_quarter_deg;
  logic [STATUS_W-1:0]        out_thermo_status;
  logic signed [JCT_W-1:0]    out_junction_sixteenth_deg;
  logic                       out_last;
  logic [OKCNT_W-1:0]         out_ok_count;
  logic signed [SUM_W-1:0]    out_junction_sum;
  logic                       out_junction_out_of_range;

  multi_thermocouple_frame_decoder dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_so_bits                (in_so_bits),
    .in_first_bit              (in_first_bit),
    .in_overwrite              (in_overwrite),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_port                  (out_port),
    .out_thermo_quarter_deg    (out_thermo_quarter_deg),
    .out_thermo_status         (out_thermo_status),
    .out_junction_sixteenth_deg(out_junction_sixteenth_deg),
    .out_last                  (out_last),
    .out_ok_count              (out_ok_count),
    .out_junction_sum          (out_junction_sum),
    .out_junction_out_of_range (out_junction_out_of_range)
  );

  // stimulus and prediction state
  slice_t       slice_queue[$];
  port_report_t report_queue[$];
  logic [FRAME_W-1:0]  frame_words [PORT_COUNT];
  logic                frame_aligned = 1'b1;

  logic [FRAME_W-1:0]  sh_frame [PORT_COUNT];
  int                  sh_count;
  logic [THERMO_W-1:0] kept_value [PORT_COUNT];
  logic [STATUS_W-1:0] kept_status [PORT_COUNT];

  int phase = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int slices_offered = 0;
  int slices_taken = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  slice_t next_slice;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shift one slice into every frame; on frame end decode and queue reports
  task automatic decode_slice(input slice_t s);
    logic [FRAME_W-1:0]      d;
    logic signed [JCT_W-1:0] jct [PORT_COUNT];
    logic [STATUS_W-1:0]     st;
    logic [THERMO_W-1:0]     val;
    logic signed [SUM_W-1:0] jsum;
    logic [OKCNT_W-1:0]      okc;
    logic                    oor;
    bit                      is_last;
    port_report_t            r;
    if (s.first_bit) begin
      for (int p = 0; p < PORT_COUNT; p++) sh_frame[p] = '0;
      sh_count = 0;
    end
    for (int p = 0; p < PORT_COUNT; p++)
      sh_frame[p] = {sh_frame[p][FRAME_W-2:0], s.so_bits[p]};
    sh_count++;
    if (sh_count < FRAME_W) return;
    sh_count = 0;
    jsum = '0;
    okc  = '0;
    oor  = 1'b0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      d = sh_frame[p];
      jct[p] = d[JCT_LSB +: JCT_W];
      jsum = jsum + {{(SUM_W-JCT_W){jct[p][JCT_W-1]}}, jct[p]};
      if (jct[p] < JCT_LOW || jct[p] > JCT_HIGH) oor = 1'b1;
      st  = ST_VALID;
      val = '0;
      if (d[FAULT_BIT]) begin
        case (d[2:0])
          FC_OPEN: st = ST_OPEN;
          FC_GND:  st = ST_GND;
          FC_VCC:  st = ST_VCC;
          default: st = ST_VALID;  // unrecognized code reads as a zero reading
        endcase
      end else begin
        val = d[THERMO_LSB +: THERMO_W];
      end
      if (s.overwrite || st == ST_VALID || kept_status[p] == ST_NEVER) begin
        kept_value[p]  = val;
        kept_status[p] = st;
      end
    end
    for (int p = 0; p < PORT_COUNT; p++)
      if (kept_status[p] == ST_VALID) okc++;
    for (int p = 0; p < PORT_COUNT; p++) begin
      is_last    = (p == PORT_COUNT - 1);
      r.port     = PORT_W'(p);
      r.thermo   = (kept_status[p] == ST_VALID) ? kept_value[p] : '0;
      r.status   = kept_status[p];
      r.jct      = jct[p];
      r.last     = is_last;
      r.ok_count = is_last ? okc : '0;
      r.jsum     = is_last ? jsum : '0;
      r.oor      = is_last && oor;
      report_queue.push_back(r);
    end
  endtask

  function automatic logic [FRAME_W-1:0] make_word(logic [THERMO_W-1:0] th, logic fault,
                                                   logic [JCT_W-1:0] jct, logic [2:0] code);
    return {th, 1'($urandom), fault, jct, 1'($urandom), code};
  endfunction

  function automatic logic [JCT_W-1:0] random_jct();
    case ($urandom_range(63, 0))
      0: return JCT_LOW;
      1: return JCT_W'(JCT_LOW - 1);
      2: return JCT_HIGH;
      3: return JCT_W'(JCT_HIGH + 1);
      4: return 12'h7FF;
      5: return 12'h800;
      6: return JCT_W'($urandom);
      default: return JCT_W'(int'($urandom_range(1760, 0)) - 160);
    endcase
  endfunction

  function automatic logic [THERMO_W-1:0] random_thermo();
    case ($urandom_range(15, 0))
      0: return 14'h1FFF;
      1: return 14'h2000;
      2: return '0;
      3: return 14'h3FFF;
      default: return THERMO_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAME_W-1:0] random_word();
    logic [2:0] code;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4:
        return make_word(random_thermo(), 1'b0, random_jct(), 3'($urandom));
      5, 6, 7: begin
        case ($urandom_range(2, 0))
          0: code = FC_OPEN;
          1: code = FC_GND;
          default: code = FC_VCC;
        endcase
        return make_word(THERMO_W'($urandom), 1'b1, random_jct(), code);
      end
      8: begin
        do code = 3'($urandom); while (code == FC_OPEN || code == FC_GND || code == FC_VCC);
        return make_word(THERMO_W'($urandom), 1'b1, random_jct(), code);
      end
      default: return FRAME_W'($urandom);
    endcase
  endfunction

  // serialize frame_words MSB first, one slice per bit position
  task automatic push_frame(logic first, logic ovw);
    slice_t s;
    for (int i = 0; i < FRAME_W; i++) begin
      for (int p = 0; p < PORT_COUNT; p++) s.so_bits[p] = frame_words[p][FRAME_W-1-i];
      s.first_bit = (i == 0) ? first : 1'b0;
      s.overwrite = (i == FRAME_W - 1) ? ovw : 1'($urandom);
      slice_queue.push_back(s);
    end
    frame_aligned = 1'b1;
  endtask

  task automatic push_directed();
    for (int p = 0; p < PORT_COUNT; p++)
      frame_words[p] = make_word(random_thermo(), 1'b0, random_jct(), 3'($urandom));
    frame_words[0]  = make_word(14'h1FFF, 1'b0, 12'h7FF, 3'b000);
    frame_words[1]  = make_word(14'h2000, 1'b0, 12'h800, 3'b111);
    frame_words[2]  = make_word(14'h3FFF, 1'b1, 12'h000, FC_OPEN);
    frame_words[3]  = make_word(14'h0000, 1'b1, 12'h000, FC_GND);
    frame_words[4]  = make_word(14'h1234, 1'b1, 12'h000, FC_VCC);
    frame_words[5]  = make_word(14'h0ABC, 1'b1, 12'h100, 3'b000);
    frame_words[6]  = make_word(14'h0ABC, 1'b1, 12'h100, 3'b111);
    frame_words[7]  = make_word(14'h0001, 1'b0, JCT_LOW, 3'b000);
    frame_words[8]  = make_word(14'h0002, 1'b0, JCT_W'(JCT_LOW - 1), 3'b000);
    frame_words[9]  = make_word(14'h0003, 1'b0, JCT_HIGH, 3'b000);
    frame_words[10] = make_word(14'h0004, 1'b0, JCT_W'(JCT_HIGH + 1), 3'b000);
    frame_words[11] = '1;
    frame_words[12] = '0;
    push_frame(1'b1, 1'b0);
    // back to back without a frame marker, faults forced over stored readings
    for (int p = 0; p < PORT_COUNT; p++)
      frame_words[p] = make_word(14'h1555, 1'b1, 12'hF60,
                                 (p % 3 == 0) ? FC_OPEN : (p % 3 == 1) ? FC_GND : FC_VCC);
    push_frame(1'b0, 1'b1);
  endtask

  // two whole frames back to back, so a held receiver fills the block
  task automatic push_pressure();
    for (int f = 0; f < 2; f++) begin
      for (int p = 0; p < PORT_COUNT; p++) frame_words[p] = random_word();
      push_frame((f == 0) ? 1'b1 : 1'b0, 1'($urandom));
    end
  endtask

  task automatic push_random(int count);
    int pushed;
    int n;
    slice_t s;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(5, 0) == 0) begin
        n = $urandom_range(40, 1);
        for (int i = 0; i < n; i++) begin
          s.so_bits   = PORT_COUNT'($urandom);
          s.first_bit = ($urandom_range(7, 0) == 0);
          s.overwrite = 1'($urandom);
          slice_queue.push_back(s);
        end
        pushed += n;
        frame_aligned = 1'b0;
      end else begin
        for (int p = 0; p < PORT_COUNT; p++) frame_words[p] = random_word();
        push_frame(frame_aligned ? 1'($urandom) : 1'b1, 1'($urandom));
        pushed += FRAME_W;
      end
    end
  endtask

  initial begin
    for (int p = 0; p < PORT_COUNT; p++) begin
      sh_frame[p]    = '0;
      kept_value[p]  = '0;
      kept_status[p] = ST_NEVER;
    end
    sh_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 1; ph <= 3; ph++) begin
      phase = ph;
      send_idle_pct = (ph == 1) ? 13 : (ph == 2) ? 70 : 0;
      recv_idle_pct = (ph == 1) ? 70 : (ph == 2) ? 13 : 0;
      if (ph == 1) push_directed();
      if (ph == 3) begin
        push_pressure();
        push_random(SLICES_PER_PHASE - 2 * FRAME_W);
      end else begin
        push_random(SLICES_PER_PHASE);
      end
      // sender holds until every queued report has come back
      while (slice_queue.size() != 0 || in_valid || report_queue.size() != 0)
        @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && report_queue.size() == 0) begin
      $display("multi_thermocouple_frame_decoder test passed");
    end else begin
      $display("multi_thermocouple_frame_decoder test failed");
    end
    $finish;
  end

  // slice driver: new slice only after the previous one transferred
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || slices_taken == slices_offered) begin
      if (slice_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_slice = slice_queue.pop_front();
        in_so_bits   <= next_slice.so_bits;
        in_first_bit <= next_slice.first_bit;
        in_overwrite <= next_slice.overwrite;
        in_valid     <= 1'b1;
        slices_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // report receiver; one long hold-off at the start of the last phase
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (phase == 3 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    port_report_t got;
    port_report_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_slice('{so_bits: in_so_bits, first_bit: in_first_bit, overwrite: in_overwrite});
        slices_taken++;
      end
      if (out_valid && !out_stall) begin
        got = '{port: out_port, thermo: out_thermo_quarter_deg, status: out_thermo_status,
                jct: out_junction_sixteenth_deg, last: out_last, ok_count: out_ok_count,
                jsum: out_junction_sum, oor: out_junction_out_of_range};
        if (report_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected report transfer, port %0d", got.port);
        end else begin
          want = report_queue.pop_front();
          if (got.port !== want.port || got.thermo !== want.thermo ||
              got.status !== want.status || got.jct !== want.jct ||
              got.last !== want.last || got.ok_count !== want.ok_count ||
              got.jsum !== want.jsum || got.oor !== want.oor) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("ERROR: report mismatch");
              $display("  exp port %0d thermo %0d st %0d jct %0d last %0b ok %0d sum %0d oor %0b",
                       want.port, want.thermo, want.status, want.jct, want.last,
                       want.ok_count, want.jsum, want.oor);
              $display("  got port %0d thermo %0d st %0d jct %0d last %0b ok %0d sum %0d oor %0b",
                       got.port, got.thermo, got.status, got.jct, got.last,
                       got.ok_count, got.jsum, got.oor);
            end
          end
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("multi_thermocouple_frame_decoder test failed");
          $finish;
        end
      end
    end
  end

endmodule
